### rtl/hsfc_pkg.sv
// Package for the half/single float converter.
// Holds the opcode codes and the field widths shared by the converter modules.
// No dependencies.
package hsfc_pkg;

  // Operand and result widths.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned HALF_W = 16;

  // Direction of conversion, chosen per item.
  localparam logic OP_SINGLE_TO_HALF = 1'b0;
  localparam logic OP_HALF_TO_SINGLE = 1'b1;

  // Single precision exponent limits for the conversion to half.
  localparam logic [7:0] S2H_ZERO_LIMIT = 8'd102;  // below this the result is signed zero
  localparam logic [7:0] S2H_SUB_LIMIT  = 8'd112;  // up to this the result is a half subnormal
  localparam logic [7:0] S2H_INF_LIMIT  = 8'd143;  // from this the result is signed infinity

  // Exponent rebias between the two formats.
  localparam logic [7:0] EXP_REBIAS = 8'd112;

endpackage

### rtl/hsfc_s2h.sv
// Single to half conversion with half-up rounding, purely combinational.
// Depends on hsfc_pkg for widths and exponent limits.
module hsfc_s2h (
  input  logic [hsfc_pkg::WORD_W-1:0] single_bits,
  output logic [hsfc_pkg::HALF_W-1:0] half_bits
);

  logic        sgn;
  logic [7:0]  exp_s;
  logic [22:0] frac;
  logic [23:0] mant;
  logic [7:0]  sh_wide;
  logic [4:0]  sh_m1;
  logic [23:0] shifted;
  logic [10:0] sub_h;
  logic [7:0]  e_wide;
  logic [14:0] norm_h;

  assign sgn   = single_bits[31];
  assign exp_s = single_bits[30:23];
  assign frac  = single_bits[22:0];
  assign mant  = {1'b1, frac};

  // Subnormal path: shift right by one less than the full shift, so that the
  // lowest remaining bit is the first dropped bit and gives the rounding.
  assign sh_wide = 8'd125 - exp_s;
  assign sh_m1   = sh_wide[4:0];
  assign shifted = mant >> sh_m1;
  assign sub_h   = shifted[11:1] + {10'b0, shifted[0]};

  // Normal path: rebias the exponent; a rounding carry runs into it.
  assign e_wide = exp_s - hsfc_pkg::EXP_REBIAS;
  assign norm_h = {e_wide[4:0], frac[22:13]} + {14'b0, frac[12]};

  // Select the range that applies.
  always_comb begin
    if (exp_s < hsfc_pkg::S2H_ZERO_LIMIT) begin
      half_bits = {sgn, 15'b0};
    end else if (exp_s <= hsfc_pkg::S2H_SUB_LIMIT) begin
      half_bits = {sgn, 4'b0, sub_h};
    end else if (exp_s >= hsfc_pkg::S2H_INF_LIMIT) begin
      half_bits = {sgn, 5'h1f, 10'b0};
    end else begin
      half_bits = {sgn, norm_h};
    end
  end

endmodule

### rtl/hsfc_h2s.sv
// Exact half to single conversion, purely combinational.
// Depends on hsfc_pkg for widths and the exponent rebias.
module hsfc_h2s (
  input  logic [hsfc_pkg::HALF_W-1:0] half_bits,
  output logic [hsfc_pkg::WORD_W-1:0] single_bits
);

  logic       sgn;
  logic [4:0] exp_h;
  logic [9:0] frac;
  logic [3:0] lz;
  logic       found;
  logic [9:0] norm_frac;
  logic [7:0] sub_exp;

  assign sgn   = half_bits[15];
  assign exp_h = half_bits[14:10];
  assign frac  = half_bits[9:0];

  // Leading-zero count of the subnormal fraction.
  always_comb begin
    lz    = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found) begin
        if (frac[i]) begin
          found = 1'b1;
        end else begin
          lz = lz + 4'd1;
        end
      end
    end
  end

  // Shift the leading one out of the fraction and lower the exponent to match.
  assign norm_frac = frac << (lz + 4'd1);
  assign sub_exp   = hsfc_pkg::EXP_REBIAS - {4'b0, lz};

  always_comb begin
    if (exp_h == 5'd0) begin
      if (frac == 10'd0) begin
        single_bits = {sgn, 31'b0};
      end else begin
        single_bits = {sgn, sub_exp, norm_frac, 13'b0};
      end
    end else if (exp_h == 5'h1f) begin
      single_bits = {sgn, 8'hff, frac, 13'b0};
    end else begin
      single_bits = {sgn, {3'b0, exp_h} + hsfc_pkg::EXP_REBIAS, frac, 13'b0};
    end
  end

endmodule

### rtl/half_single_float_converter.sv
// Converts one floating-point bit pattern per transfer between binary32 and
// binary16, the direction chosen by in_opcode. An item passes through an input
// register and then a result register with the conversion logic between them,
// and it is offered at the output from the result register until it is taken.
// One item is taken every cycle while the output is not stalled. While a
// result waits, the input register takes an item only when it is empty, and
// in_stall rises only when both registers are full and out_stall is high.
// Depends on hsfc_pkg, hsfc_s2h and hsfc_h2s.
module half_single_float_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_bits
);

  logic        s1_valid_r;
  logic        s1_opcode_r;
  logic [31:0] s1_operand_r;
  logic        out_valid_r;
  logic [31:0] out_result_r;
  logic        out_load;
  logic        s1_load;
  logic [15:0] half_res;
  logic [31:0] single_res;
  logic [31:0] result_nxt;

  // The result register moves when it is empty or its content is taken.
  assign out_load = !out_valid_r || !out_stall;
  // The input register moves when empty or when its item goes on.
  assign s1_load  = !s1_valid_r || out_load;
  assign in_stall = !s1_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
    if (s1_load && in_valid) begin
      s1_opcode_r  <= in_opcode;
      s1_operand_r <= in_operand_bits;
    end
  end

  // Conversion in both directions; the opcode picks one.
  hsfc_s2h u_s2h (
    .single_bits (s1_operand_r),
    .half_bits   (half_res)
  );

  hsfc_h2s u_h2s (
    .half_bits   (s1_operand_r[15:0]),
    .single_bits (single_res)
  );

  always_comb begin
    if (s1_opcode_r == hsfc_pkg::OP_HALF_TO_SINGLE) begin
      result_nxt = single_res;
    end else begin
      result_nxt = {16'b0, half_res};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
    if (out_load && s1_valid_r) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_result_r;

endmodule

### rtl/hsfc_checker.sv
// Port-level checks for the half/single float converter, bound to the top level.
// Depends only on the ports of half_single_float_converter.
module hsfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result_bits
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // The input side is held back only by a stalled result.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_bits))
    else $error("out_result_bits changed while stalled");

endmodule

bind half_single_float_converter hsfc_checker u_hsfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_bits (out_result_bits)
);
